// File: hdl/gf256_arithmetic_unit_core_macros.svh
// assertion macros for the gf256 arithmetic unit
`ifndef GF256_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define GF256_ARITHMETIC_UNIT_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define GF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gf256 assertion failed");

`define GF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gf256 assertion failed");

`else

`define GF_ASSERT(label, clk, rst_n, prop)

`define GF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: hdl/gf256_pkg.sv
// types, constants and field functions for the gf256 arithmetic unit
`timescale 1ns / 1ps

package gf256_pkg;

    localparam logic [7:0] GF_REDUCE_LOW = 8'h1B;
    localparam logic [8:0] GF_POLY       = 9'h11B;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [7:0] a;
        logic [7:0] b;
    } item_t;

    typedef struct packed {
        item_t      item;
        logic [7:0] inv;
    } inv_item_t;

    // carry-less product reduced by the field polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = '0;
        sh  = x;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) begin
                acc = acc ^ sh;
            end
            sh = {sh[6:0], 1'b0} ^ (sh[7] ? GF_REDUCE_LOW : 8'h00);
        end
        return acc;
    endfunction

    // squaring is linear: spread bits to even places, then reduce
    function automatic logic [7:0] gf_sq(input logic [7:0] x);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            p[2*i] = x[i];
        end
        for (int k = 14; k >= 8; k--) begin
            if (p[k]) begin
                p[k-8 +: 9] = p[k-8 +: 9] ^ GF_POLY;
            end
        end
        return p[7:0];
    endfunction

endpackage

// File: hdl/gf256_arithmetic_unit_core.sv
// top level of the gf256 arithmetic unit: inverse pipeline and result stage
//
// channel   direction  tdata                  tuser
// s_        in         a[7:0], b[15:8]        op[1:0]
// m_        out        product[7:0]           div_by_zero[0]
//
// one item per cycle sustained while m_ does not stall
// depth set by the inverse chain: one field multiply in series per stage
// aresetn clears all stage valid bits, no clearing pass
// a stall at m_ holds every stage; s_tready follows the output register
`timescale 1ns / 1ps
`include "gf256_arithmetic_unit_core_macros.svh"

module gf256_arithmetic_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operand_a, operand_b
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // product
    output logic [0:0]  m_tuser    // div_by_zero
);

    logic                  en;
    gf256_pkg::item_t      in_item;
    gf256_pkg::inv_item_t  inv_item;
    logic                  out_valid_reg;
    logic [7:0]            product_reg, product_next;
    logic                  dz_reg, dz_next;
    gf256_pkg::op_t        op_reg;

    assign en = !out_valid_reg || m_tready;

    assign in_item.valid = s_tvalid;
    assign in_item.op    = gf256_pkg::op_t'(s_tuser);
    assign in_item.a     = s_tdata[7:0];
    assign in_item.b     = s_tdata[15:8];

    gf256_inv_pipe u_inv_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_item  (in_item),
        .out_item (inv_item)
    );

    // stage 4: operation select
    always_comb begin
        product_next = '0;
        dz_next      = 1'b0;
        case (inv_item.item.op)
            gf256_pkg::OP_ADD,
            gf256_pkg::OP_SUB: begin
                product_next = inv_item.item.a ^ inv_item.item.b;
            end
            gf256_pkg::OP_MUL: begin
                product_next = gf256_pkg::gf_mul(inv_item.item.a, inv_item.item.b);
            end
            gf256_pkg::OP_DIV: begin
                if (inv_item.item.b == 8'h00) begin
                    dz_next = 1'b1;
                end else begin
                    product_next = gf256_pkg::gf_mul(inv_item.item.a, inv_item.inv);
                end
            end
            default: begin
                product_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= inv_item.item.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= product_next;
            dz_reg      <= dz_next;
            op_reg      <= inv_item.item.op;
        end
    end

    assign s_tready   = en;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = product_reg;
    assign m_tuser[0] = dz_reg;

    `GF_ASSERT(a_dz_zero_product, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h00))
    `GF_ASSERT(a_dz_only_div, aclk, aresetn, (m_tvalid && op_reg != gf256_pkg::OP_DIV) |-> !m_tuser[0])
    `GF_ASSERT(a_stall_from_out, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready))
    `GF_ASSERT_ALWAYS(a_reset_empty, aclk, $past(!aresetn) |-> !m_tvalid)

endmodule

// File: hdl/gf256_inv_pipe.sv
// three-stage inverse pipeline, b^254 by an addition chain
`timescale 1ns / 1ps

module gf256_inv_pipe (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  gf256_pkg::item_t      in_item,
    output gf256_pkg::inv_item_t  out_item
);

    gf256_pkg::item_t item1_reg, item2_reg, item3_reg;
    logic [7:0] x2_reg, x3_reg, x14_reg, x15_reg, inv_reg;
    logic [7:0] x2_next, x3_next, x14_next, x15_next, inv_next;
    logic [7:0] x12, x240;

    // stage 1: b^2, b^3
    always_comb begin
        x2_next = gf256_pkg::gf_sq(in_item.b);
        x3_next = gf256_pkg::gf_mul(x2_next, in_item.b);
    end

    // stage 2: b^12, then b^14 and b^15
    always_comb begin
        x12      = gf256_pkg::gf_sq(gf256_pkg::gf_sq(x3_reg));
        x14_next = gf256_pkg::gf_mul(x12, x2_reg);
        x15_next = gf256_pkg::gf_mul(x12, x3_reg);
    end

    // stage 3: b^240 * b^14
    always_comb begin
        x240     = gf256_pkg::gf_sq(gf256_pkg::gf_sq(
                   gf256_pkg::gf_sq(gf256_pkg::gf_sq(x15_reg))));
        inv_next = gf256_pkg::gf_mul(x240, x14_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item1_reg.valid <= 1'b0;
            item2_reg.valid <= 1'b0;
            item3_reg.valid <= 1'b0;
        end else if (en) begin
            item1_reg.valid <= in_item.valid;
            item2_reg.valid <= item1_reg.valid;
            item3_reg.valid <= item2_reg.valid;
        end
        if (en) begin
            item1_reg.op <= in_item.op;
            item1_reg.a  <= in_item.a;
            item1_reg.b  <= in_item.b;
            item2_reg.op <= item1_reg.op;
            item2_reg.a  <= item1_reg.a;
            item2_reg.b  <= item1_reg.b;
            item3_reg.op <= item2_reg.op;
            item3_reg.a  <= item2_reg.a;
            item3_reg.b  <= item2_reg.b;
            x2_reg       <= x2_next;
            x3_reg       <= x3_next;
            x14_reg      <= x14_next;
            x15_reg      <= x15_next;
            inv_reg      <= inv_next;
        end
    end

    assign out_item.item = item3_reg;
    assign out_item.inv  = inv_reg;

endmodule

// File: sim/tb.sv
// self-checking testbench for the gf256 arithmetic unit core
`timescale 1ns / 1ps

module tb;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CALM_FIRST    = 500;
    localparam int CALM_LAST     = 800;
    localparam int IDLE_PERCENT  = 22;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        gf256_pkg::op_t op;
        logic [7:0]     a;
        logic [7:0]     b;
    } field_op_t;

    typedef struct packed {
        logic [7:0] product;
        logic       div_by_zero;
    } field_result_t;

    typedef struct packed {
        field_op_t     req;
        logic          typed;
        field_result_t want;
    } request_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // operand_a, operand_b
    logic [1:0]  s_tuser  = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // product
    logic [0:0]  m_tuser;         // div_by_zero

    request_row_t  directed_rows [0:DIRECTED_ROWS-1];
    request_row_t  pending_requests [$];
    field_result_t expected_results [$];
    request_row_t  next_row;
    request_row_t  fresh_row;
    field_result_t in_flight_want;
    field_result_t got;
    field_result_t want;

    int accepted_count = 0;
    int received_count = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    gf256_arithmetic_unit_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // horner form: shift-and-reduce the accumulator, add x where y has a one
    function automatic logic [7:0] field_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? gf256_pkg::GF_REDUCE_LOW : 8'h00);
            if (y[i]) begin
                acc = acc ^ x;
            end
        end
        return acc;
    endfunction

    // the unique q with divisor * q = dividend, by search
    function automatic logic [7:0] field_quotient(input logic [7:0] dividend,
                                                  input logic [7:0] divisor);
        logic [7:0] q;
        q = 8'h00;
        for (int c = 0; c < 256; c++) begin
            if (field_mul(divisor, c[7:0]) == dividend) begin
                q = c[7:0];
            end
        end
        return q;
    endfunction

    function automatic field_result_t predict_result(input field_op_t r);
        field_result_t res;
        res = '0;
        case (r.op)
            gf256_pkg::OP_ADD, gf256_pkg::OP_SUB: begin
                res.product = r.a ^ r.b;
            end
            gf256_pkg::OP_MUL: begin
                res.product = field_mul(r.a, r.b);
            end
            default: begin
                if (r.b == 8'h00) begin
                    res.div_by_zero = 1'b1;
                end else begin
                    res.product = field_quotient(r.a, r.b);
                end
            end
        endcase
        return res;
    endfunction

    // edge values show up often, the rest is uniform
    function automatic logic [7:0] pick_operand();
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'h01;
            3:       v = 8'h01 << $urandom_range(0, 7);
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic bit idle_now(input int count);
        return !(count >= CALM_FIRST && count < CALM_LAST) &&
               ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("item %0d: %s expected %h, got %h", received_count, what, exp_v, act_v);
        end
    endtask

    task automatic check_result();
        got = '{product: m_tdata, div_by_zero: m_tuser[0]};
        if (expected_results.size() == 0) begin
            note_mismatch("unexpected item, product", 8'h00, got.product);
        end else begin
            want = expected_results.pop_front();
            if (got.product !== want.product) begin
                note_mismatch("product", want.product, got.product);
            end
            if (got.div_by_zero !== want.div_by_zero) begin
                note_mismatch("div_by_zero", {7'd0, want.div_by_zero},
                              {7'd0, got.div_by_zero});
            end
        end
        received_count++;
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(in_flight_want);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && !idle_now(accepted_count)) begin
                    next_row = pending_requests.pop_front();
                    in_flight_want = next_row.typed ? next_row.want
                                                    : predict_result(next_row.req);
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_row.req.b, next_row.req.a};
                    s_tuser  <= next_row.req.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            m_tready <= !idle_now(received_count);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[gf256_arithmetic_unit_core] ERROR");
            $finish;
        end
    end

    initial begin
        // op, a, b, typed, product, div_by_zero
        directed_rows = '{
            {gf256_pkg::OP_ADD, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
            {gf256_pkg::OP_ADD, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
            {gf256_pkg::OP_ADD, 8'hFF, 8'h00, 1'b1, 8'hFF, 1'b0},
            {gf256_pkg::OP_SUB, 8'hA5, 8'h5A, 1'b1, 8'hFF, 1'b0},
            {gf256_pkg::OP_SUB, 8'h00, 8'hFF, 1'b1, 8'hFF, 1'b0},
            {gf256_pkg::OP_SUB, 8'h3C, 8'h3C, 1'b1, 8'h00, 1'b0},
            {gf256_pkg::OP_MUL, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
            {gf256_pkg::OP_MUL, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
            {gf256_pkg::OP_MUL, 8'h01, 8'hB7, 1'b1, 8'hB7, 1'b0},
            {gf256_pkg::OP_MUL, 8'h02, 8'h80, 1'b1, 8'h1B, 1'b0},
            {gf256_pkg::OP_MUL, 8'h57, 8'h83, 1'b1, 8'hC1, 1'b0},
            {gf256_pkg::OP_MUL, 8'h53, 8'hCA, 1'b1, 8'h01, 1'b0},
            {gf256_pkg::OP_MUL, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
            {gf256_pkg::OP_MUL, 8'h80, 8'h80, 1'b0, 8'h00, 1'b0},
            {gf256_pkg::OP_DIV, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
            {gf256_pkg::OP_DIV, 8'h37, 8'h00, 1'b1, 8'h00, 1'b1},
            {gf256_pkg::OP_DIV, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b1},
            {gf256_pkg::OP_DIV, 8'h00, 8'h01, 1'b1, 8'h00, 1'b0},
            {gf256_pkg::OP_DIV, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
            {gf256_pkg::OP_DIV, 8'h53, 8'h01, 1'b1, 8'h53, 1'b0},
            {gf256_pkg::OP_DIV, 8'h01, 8'h53, 1'b1, 8'hCA, 1'b0},
            {gf256_pkg::OP_DIV, 8'h57, 8'h13, 1'b0, 8'h00, 1'b0}
        };
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            pending_requests.push_back(directed_rows[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            fresh_row       = '0;
            fresh_row.req.op = gf256_pkg::op_t'($urandom_range(0, 3));
            fresh_row.req.a  = pick_operand();
            fresh_row.req.b  = pick_operand();
            pending_requests.push_back(fresh_row);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[gf256_arithmetic_unit_core] OK");
        end else begin
            $display("[gf256_arithmetic_unit_core] ERROR");
        end
        $finish;
    end

endmodule

// File: gf256_arithmetic_unit_core.f
+incdir+hdl
hdl/gf256_pkg.sv
hdl/gf256_inv_pipe.sv
hdl/gf256_arithmetic_unit_core.sv
sim/tb.sv
